### rtl/srit_pkg.sv
package srit_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int TEMP_W  = 16;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;

  // Most matches reported by one query
  localparam int MAX_RESULTS = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_NEG    = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_REPORT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE     = 2'd3;

  // One stored record
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Stored record a sorts ahead of new record b: lower temperature, or equal
  // temperature with a date no earlier than b's
  function automatic logic goes_before(rec_t a, rec_t b);
    logic lt;
    logic eq;
    lt = $signed(a.temp) < $signed(b.temp);
    eq = a.temp == b.temp;
    goes_before = lt || (eq && ({a.year, a.month, a.day} >= {b.year, b.month, b.day}));
  endfunction

endpackage

### rtl/srit_ram.sv
module srit_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sorted_record_insert_table_unit.sv
// Channel   Ports                                    Beat taken when
// -------   --------------------------------------   ----------------------
// input     in_operation, in_temperature, in_year,   start && !busy
//           in_month, in_day
// result    out_status, out_position, out_record_*,  out_strobe (one cycle)
//           out_match_count, out_last
//
// Records live in one RAM with a registered read; the sequencer walks it one
// entry per cycle. Insert shifts entries up from the top until its slot is
// found. A query scans every stored entry, or stops early once the match
// limit ends the scan. Full-table insert and empty-table query report straight
// from idle; the unused code is taken but gives no result.
// Reset (rst_n low, synchronous) empties the table; the RAM itself is not
// cleared. Results cannot be stalled; busy holds off new beats.
module sorted_record_insert_table_unit #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [srit_pkg::OP_W-1:0]            in_operation,
  input  logic signed [srit_pkg::TEMP_W-1:0]   in_temperature,
  input  logic [srit_pkg::YEAR_W-1:0]          in_year,
  input  logic [srit_pkg::MONTH_W-1:0]         in_month,
  input  logic [srit_pkg::DAY_W-1:0]           in_day,
  output logic                                 out_strobe,
  output logic [srit_pkg::STAT_W-1:0]          out_status,
  output logic [srit_pkg::POS_W-1:0]           out_position,
  output logic signed [srit_pkg::TEMP_W-1:0]   out_record_temperature,
  output logic [srit_pkg::YEAR_W-1:0]          out_record_year,
  output logic [srit_pkg::MONTH_W-1:0]         out_record_month,
  output logic [srit_pkg::DAY_W-1:0]           out_record_day,
  output logic [srit_pkg::CNT_W-1:0]           out_match_count,
  output logic                                 out_last
);

  import srit_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_INS_HEAD = 3'd2;
  localparam logic [2:0] S_QRY      = 3'd3;
  localparam logic [2:0] S_QFIN     = 3'd4;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          strobe_r, strobe_nxt;

  // Working payload
  logic [AW-1:0]     idx_r, idx_nxt;
  rec_t              nr_r, nr_nxt;
  logic              neg_r, neg_nxt;
  logic [TEMP_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  rec_t              pend_rec_r, pend_rec_nxt;
  logic [POS_W-1:0]  pend_pos_r, pend_pos_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  // Result registers
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  rec_t              orec_r, orec_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rec_t          wrec;
  logic [REC_W-1:0] rd_data;
  rec_t          rd_rec;

  logic          accept;
  rec_t          in_rec;
  logic [AW-1:0] idx_inc;
  logic          hit;
  logic          scan_end;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign in_rec  = '{temp: in_temperature, year: in_year, month: in_month, day: in_day};
  assign rd_rec  = rec_t'(rd_data);
  assign idx_inc = idx_r + AW'(1);
  assign hit     = neg_r ? ($signed(rd_rec.temp) < 0) : (rd_rec.temp == key_r);
  assign scan_end = (CW'(idx_r) + CW'(1)) == count_r;

  srit_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrec),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pend_v_nxt   = pend_v_r;
    idx_nxt      = idx_r;
    nr_nxt       = nr_r;
    neg_nxt      = neg_r;
    key_nxt      = key_r;
    n_nxt        = n_r;
    pend_rec_nxt = pend_rec_r;
    pend_pos_nxt = pend_pos_r;
    pend_cnt_nxt = pend_cnt_r;
    strobe_nxt   = 1'b0;
    stat_nxt     = stat_r;
    pos_nxt      = pos_r;
    orec_nxt     = orec_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = olast_r;
    we           = 1'b0;
    waddr        = idx_inc;
    wrec         = rd_rec;
    raddr        = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_INSERT: begin
              nr_nxt = in_rec;
              if (count_r == CW'(DEPTH)) begin
                // table full: drop and report
                strobe_nxt = 1'b1;
                stat_nxt   = ST_FULL;
                pos_nxt    = '0;
                orec_nxt   = in_rec;
                ocnt_nxt   = '0;
                olast_nxt  = 1'b1;
              end else if (count_r == '0) begin
                state_nxt = S_INS_HEAD;
              end else begin
                idx_nxt   = AW'(count_r - CW'(1));
                raddr     = AW'(count_r - CW'(1));
                state_nxt = S_INS_CMP;
              end
            end
            OP_NEG, OP_FIND: begin
              neg_nxt    = (in_operation == OP_NEG);
              key_nxt    = in_temperature;
              n_nxt      = '0;
              pend_v_nxt = 1'b0;
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
                stat_nxt   = ST_NONE;
                pos_nxt    = '0;
                orec_nxt   = '0;
                ocnt_nxt   = '0;
                olast_nxt  = 1'b1;
              end else begin
                idx_nxt   = '0;
                raddr     = '0;
                state_nxt = S_QRY;
              end
            end
            default: ;
          endcase
        end
      end

      // Walk down from the top, moving each entry up one slot
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = idx_inc;
        if (goes_before(rd_rec, nr_r)) begin
          wrec       = nr_r;
          count_nxt  = count_r + CW'(1);
          strobe_nxt = 1'b1;
          stat_nxt   = ST_INSERTED;
          pos_nxt    = POS_W'(idx_inc);
          orec_nxt   = nr_r;
          ocnt_nxt   = '0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          wrec = rd_rec;
          if (idx_r == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            idx_nxt = idx_r - AW'(1);
            raddr   = idx_r - AW'(1);
          end
        end
      end

      // New record goes to the front
      S_INS_HEAD: begin
        we         = 1'b1;
        waddr      = '0;
        wrec       = nr_r;
        count_nxt  = count_r + CW'(1);
        strobe_nxt = 1'b1;
        stat_nxt   = ST_INSERTED;
        pos_nxt    = '0;
        orec_nxt   = nr_r;
        ocnt_nxt   = '0;
        olast_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end

      // Scan; a match is held back one beat so the final one can carry last
      S_QRY: begin
        if (hit) begin
          n_nxt = n_r + CNT_W'(1);
          if (pend_v_r) begin
            strobe_nxt = 1'b1;
            stat_nxt   = ST_REPORT;
            pos_nxt    = pend_pos_r;
            orec_nxt   = pend_rec_r;
            ocnt_nxt   = pend_cnt_r;
            olast_nxt  = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_rec_nxt = rd_rec;
          pend_pos_nxt = POS_W'(idx_r);
          pend_cnt_nxt = n_r + CNT_W'(1);
        end
        if (scan_end || (hit && n_r == CNT_W'(MAX_RESULTS - 1))) begin
          state_nxt = S_QFIN;
        end else begin
          idx_nxt = idx_inc;
          raddr   = idx_inc;
        end
      end

      S_QFIN: begin
        strobe_nxt = 1'b1;
        olast_nxt  = 1'b1;
        if (pend_v_r) begin
          stat_nxt = ST_REPORT;
          pos_nxt  = pend_pos_r;
          orec_nxt = pend_rec_r;
          ocnt_nxt = pend_cnt_r;
        end else begin
          stat_nxt = ST_NONE;
          pos_nxt  = '0;
          orec_nxt = '0;
          ocnt_nxt = '0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    nr_r       <= nr_nxt;
    neg_r      <= neg_nxt;
    key_r      <= key_nxt;
    n_r        <= n_nxt;
    pend_rec_r <= pend_rec_nxt;
    pend_pos_r <= pend_pos_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    stat_r     <= stat_nxt;
    pos_r      <= pos_nxt;
    orec_r     <= orec_nxt;
    ocnt_r     <= ocnt_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_strobe             = strobe_r;
  assign out_status             = stat_r;
  assign out_position           = pos_r;
  assign out_record_temperature = orec_r.temp;
  assign out_record_year        = orec_r.year;
  assign out_record_month       = orec_r.month;
  assign out_record_day         = orec_r.day;
  assign out_match_count        = ocnt_r;
  assign out_last               = olast_r;

endmodule
